/* src/pcsd_pkg.sv */
// Shared types and constants of the percentile-calibrated streak detector.
// No dependencies; the files that use this package refer to it by scoped names.
`timescale 1ns / 1ps

package pcsd_pkg;

    localparam int RING_DEPTH_DEF = 128;
    localparam int COUNT_BITS_DEF = 16;
    localparam int TIME_BITS_DEF  = 32;

    localparam logic [1:0] MODE_DIS = 2'd0;
    localparam logic [1:0] MODE_CAL = 2'd1;
    localparam logic [1:0] MODE_ARM = 2'd2;

    localparam logic OP_WINDOW  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic [2:0] REG_ENABLE       = 3'd0;
    localparam logic [2:0] REG_CALIB_TIME   = 3'd1;
    localparam logic [2:0] REG_GAIN         = 3'd2;
    localparam logic [2:0] REG_STREAK_NEED  = 3'd3;
    localparam logic [2:0] REG_DEAUTH_NEED  = 3'd4;
    localparam logic [2:0] REG_CLEAR_NEED   = 3'd5;
    localparam logic [2:0] REG_MIN_SAMPLES  = 3'd6;

    localparam logic [31:0] ONE_Q8   = 32'd256;
    localparam logic [7:0]  RUN_MAX  = 8'd255;
    // floor(x / 10) is approximated by (x * RECIP_TEN) >> RECIP_SHIFT, then corrected
    localparam logic [15:0] RECIP_TEN   = 16'd52429;
    localparam int          RECIP_SHIFT = 19;

    typedef struct packed {
        logic        enable;
        logic [31:0] calib_time_ms;
        logic [15:0] gain_q8;
        logic [7:0]  streak_need;
        logic [7:0]  deauth_streak_need;
        logic [7:0]  clear_need;
        logic [7:0]  min_samples;
    } cfg_t;

endpackage

/* src/pcsd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pcsd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/pcsd_front.sv */
// Front end: accepts input transfers and holds them in a two-entry queue.
// Depends on pcsd_pkg for the opcode codes.
`timescale 1ns / 1ps

module pcsd_front #(
    parameter int COUNT_BITS = pcsd_pkg::COUNT_BITS_DEF,
    parameter int TIME_BITS  = pcsd_pkg::TIME_BITS_DEF,
    localparam int ITEM_W    = 3 + TIME_BITS + COUNT_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  valid,
    output logic                  ready,
    input  logic                  opcode,
    input  logic [TIME_BITS-1:0]  now_ms,
    input  logic [COUNT_BITS-1:0] packet_count,
    input  logic                  deauth_seen,
    input  logic                  raw_alert,
    output logic                  q_valid,
    output logic [ITEM_W-1:0]     q_item,
    input  logic                  q_pop
);

    logic [ITEM_W-1:0] entry_reg [2];
    logic [1:0]        fill_reg;
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic              push;
    logic              is_restart;

    // A restart carries no traffic, so its flags are dropped here.
    assign is_restart = (opcode == pcsd_pkg::OP_RESTART);
    assign ready      = (fill_reg != 2'd2);
    assign push       = valid && ready;
    assign q_valid    = (fill_reg != 2'd0);
    assign q_item     = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= {opcode, now_ms, packet_count,
                                      deauth_seen && !is_restart,
                                      raw_alert && !is_restart};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop && q_valid)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !(q_pop && q_valid))
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (!push && q_pop && q_valid)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

/* src/pcsd_back.sv */
// Back end: sample ring, rank selection, threshold and streak logic, result register.
// Depends on pcsd_pkg and pcsd_ram.
`timescale 1ns / 1ps

module pcsd_back #(
    parameter int RING_DEPTH = pcsd_pkg::RING_DEPTH_DEF,
    parameter int COUNT_BITS = pcsd_pkg::COUNT_BITS_DEF,
    parameter int TIME_BITS  = pcsd_pkg::TIME_BITS_DEF,
    localparam int ITEM_W    = 3 + TIME_BITS + COUNT_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pcsd_pkg::cfg_t        cfg,
    input  logic                  q_valid,
    input  logic [ITEM_W-1:0]     q_item,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  alert,
    output logic [1:0]            mode,
    output logic [31:0]           threshold_q8,
    output logic [COUNT_BITS-1:0] p90_count
);

    localparam int PW = $clog2(RING_DEPTH);
    localparam int FW = $clog2(RING_DEPTH + 1);
    localparam int XW = FW + 4;
    localparam int KW = XW + 16;
    localparam int MW = COUNT_BITS + 16;
    localparam logic [FW-1:0] DEPTH_N = FW'(RING_DEPTH);
    localparam logic [PW-1:0] LAST_POS = PW'(RING_DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_KMUL, S_KFIX, S_SCAN, S_BIT, S_MUL, S_THR, S_JUDGE, S_OUT
    } state_t;

    state_t                state_reg;
    logic                  op_reg;
    logic [TIME_BITS-1:0]  now_reg;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic                  deauth_reg;
    logic                  raw_reg;

    logic [1:0]            mode_reg;
    logic [TIME_BITS-1:0]  start_reg;
    logic [PW-1:0]         pos_reg;
    logic [FW-1:0]         fill_reg;
    logic [COUNT_BITS-1:0] p90_reg;
    logic [31:0]           thr_reg;
    logic [7:0]            hit_reg;
    logic [7:0]            miss_reg;
    logic                  latch_reg;
    logic                  res_alert_reg;

    logic [FW-1:0]         n_reg;
    logic [KW-1:0]         kprod_reg;
    logic [FW-1:0]         k_reg;
    logic [FW-1:0]         issue_reg;
    logic                  pend_reg;
    logic [FW-1:0]         c_reg;
    logic [COUNT_BITS-1:0] sel_reg;
    logic [COUNT_BITS-1:0] mask_reg;
    logic [COUNT_BITS-1:0] prefix_reg;
    logic [MW-1:0]         prod_reg;

    logic                  out_valid_reg;
    logic                  alert_reg;
    logic [1:0]            mode_out_reg;
    logic [31:0]           thr_out_reg;
    logic [COUNT_BITS-1:0] p90_out_reg;

    logic                  ram_we;
    logic [COUNT_BITS-1:0] rdata;
    logic [TIME_BITS-1:0]  elapsed;
    logic [FW-1:0]         fill_next;
    logic                  arm_ok;
    logic [XW-1:0]         x_val;
    logic [XW-1:0]         q_val;
    logic [XW+3:0]         r_val;
    logic                  match;
    logic [COUNT_BITS-1:0] prefix_next;
    logic [63:0]           prod_ext;
    logic [31:0]           thr_next;
    logic [7:0]            need;
    logic                  cand;
    logic [7:0]            hit_next;
    logic [7:0]            miss_next;
    logic                  latch_next;

    assign ram_we = (state_reg == S_EXEC) && (op_reg == pcsd_pkg::OP_WINDOW) && cfg.enable
                    && (mode_reg == pcsd_pkg::MODE_CAL) && !deauth_reg;

    pcsd_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (cnt_reg),
        .raddr (issue_reg[PW-1:0]),
        .rdata (rdata)
    );

    assign q_pop        = (state_reg == S_IDLE) && q_valid;
    assign out_valid    = out_valid_reg;
    assign alert        = alert_reg;
    assign mode         = mode_out_reg;
    assign threshold_q8 = thr_out_reg;
    assign p90_count    = p90_out_reg;

    always_comb
    begin
        elapsed   = now_reg - start_reg;
        fill_next = (!deauth_reg && fill_reg < DEPTH_N) ? fill_reg + FW'(1) : fill_reg;
        arm_ok    = (64'(elapsed) >= 64'(cfg.calib_time_ms))
                    && (16'(fill_next) >= 16'(cfg.min_samples));
        // Rank index floor((n-1)*9/10) via a reciprocal with one correction step
        x_val     = XW'(n_reg - FW'(1)) * XW'(9);
        q_val     = XW'(kprod_reg >> pcsd_pkg::RECIP_SHIFT);
        r_val     = (XW+4)'(x_val) - (XW+4)'(q_val) * (XW+4)'(10);
        match     = (((rdata ^ prefix_reg) & mask_reg) == '0) && ((rdata & sel_reg) == '0);
        prefix_next = (k_reg < c_reg) ? prefix_reg : (prefix_reg | sel_reg);
        prod_ext  = 64'(prod_reg);
        if (prod_ext[63:32] != 32'd0)
        begin
            thr_next = 32'hFFFF_FFFF;
        end
        else if (prod_ext[31:0] < pcsd_pkg::ONE_Q8)
        begin
            thr_next = pcsd_pkg::ONE_Q8;
        end
        else
        begin
            thr_next = prod_ext[31:0];
        end
        need = deauth_reg ? cfg.deauth_streak_need : cfg.streak_need;
        if (need == 8'd0)
        begin
            need = 8'd1;
        end
        cand = raw_reg && (deauth_reg || (64'({cnt_reg, 8'd0}) > 64'(thr_reg)));
        hit_next   = 8'd0;
        miss_next  = 8'd0;
        latch_next = latch_reg;
        if (cand)
        begin
            hit_next = (hit_reg == pcsd_pkg::RUN_MAX) ? hit_reg : hit_reg + 8'd1;
            if (hit_next >= need)
            begin
                latch_next = 1'b1;
            end
        end
        else
        begin
            miss_next = (miss_reg == pcsd_pkg::RUN_MAX) ? miss_reg : miss_reg + 8'd1;
            if (miss_next >= cfg.clear_need)
            begin
                latch_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            {op_reg, now_reg, cnt_reg, deauth_reg, raw_reg} <= q_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= pcsd_pkg::MODE_DIS;
            start_reg     <= '0;
            pos_reg       <= '0;
            fill_reg      <= '0;
            p90_reg       <= '0;
            thr_reg       <= pcsd_pkg::ONE_Q8;
            hit_reg       <= '0;
            miss_reg      <= '0;
            latch_reg     <= 1'b0;
            res_alert_reg <= 1'b0;
            n_reg         <= '0;
            kprod_reg     <= '0;
            k_reg         <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            c_reg         <= '0;
            sel_reg       <= '0;
            mask_reg      <= '0;
            prefix_reg    <= '0;
            prod_reg      <= '0;
            out_valid_reg <= 1'b0;
            alert_reg     <= 1'b0;
            mode_out_reg  <= pcsd_pkg::MODE_DIS;
            thr_out_reg   <= pcsd_pkg::ONE_Q8;
            p90_out_reg   <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    res_alert_reg <= 1'b0;
                    state_reg     <= S_OUT;
                    if (op_reg == pcsd_pkg::OP_RESTART)
                    begin
                        latch_reg <= 1'b0;
                        if (!cfg.enable)
                        begin
                            mode_reg <= pcsd_pkg::MODE_DIS;
                        end
                        else
                        begin
                            pos_reg   <= '0;
                            fill_reg  <= '0;
                            p90_reg   <= '0;
                            thr_reg   <= pcsd_pkg::ONE_Q8;
                            hit_reg   <= '0;
                            miss_reg  <= '0;
                            start_reg <= now_reg;
                            mode_reg  <= pcsd_pkg::MODE_CAL;
                        end
                    end
                    else if (!cfg.enable || mode_reg == pcsd_pkg::MODE_DIS)
                    begin
                        res_alert_reg <= raw_reg;
                    end
                    else if (mode_reg == pcsd_pkg::MODE_CAL)
                    begin
                        if (!deauth_reg)
                        begin
                            pos_reg <= (pos_reg == LAST_POS) ? '0 : pos_reg + PW'(1);
                        end
                        fill_reg <= fill_next;
                        n_reg    <= fill_next;
                        if (arm_ok)
                        begin
                            state_reg <= S_KMUL;
                        end
                        else
                        begin
                            hit_reg   <= '0;
                            miss_reg  <= '0;
                            latch_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        state_reg <= S_JUDGE;
                    end
                end
                S_KMUL:
                begin
                    if (n_reg == '0)
                    begin
                        p90_reg   <= '0;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        kprod_reg <= KW'(x_val) * KW'(pcsd_pkg::RECIP_TEN);
                        state_reg <= S_KFIX;
                    end
                end
                S_KFIX:
                begin
                    k_reg      <= (r_val >= (XW+4)'(10)) ? FW'(q_val + XW'(1)) : FW'(q_val);
                    sel_reg    <= {1'b1, {(COUNT_BITS-1){1'b0}}};
                    mask_reg   <= '0;
                    prefix_reg <= '0;
                    c_reg      <= '0;
                    issue_reg  <= '0;
                    pend_reg   <= 1'b0;
                    state_reg  <= S_SCAN;
                end
                S_SCAN:
                begin
                    // One ring read per cycle; data is counted in the cycle after its address.
                    if (issue_reg < n_reg)
                    begin
                        issue_reg <= issue_reg + FW'(1);
                        pend_reg  <= 1'b1;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end
                    if (pend_reg && match)
                    begin
                        c_reg <= c_reg + FW'(1);
                    end
                    if (issue_reg == n_reg && !pend_reg)
                    begin
                        state_reg <= S_BIT;
                    end
                end
                S_BIT:
                begin
                    // Elements that match the current prefix with a zero here rank first.
                    if (!(k_reg < c_reg))
                    begin
                        k_reg <= k_reg - c_reg;
                    end
                    prefix_reg <= prefix_next;
                    if (sel_reg[0])
                    begin
                        p90_reg   <= prefix_next;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        mask_reg  <= mask_reg | sel_reg;
                        sel_reg   <= sel_reg >> 1;
                        c_reg     <= '0;
                        issue_reg <= '0;
                        pend_reg  <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= MW'(cfg.gain_q8) * MW'(p90_reg);
                    state_reg <= S_THR;
                end
                S_THR:
                begin
                    thr_reg   <= thr_next;
                    mode_reg  <= pcsd_pkg::MODE_ARM;
                    hit_reg   <= '0;
                    miss_reg  <= '0;
                    latch_reg <= 1'b0;
                    state_reg <= S_JUDGE;
                end
                S_JUDGE:
                begin
                    hit_reg       <= hit_next;
                    miss_reg      <= miss_next;
                    latch_reg     <= latch_next;
                    res_alert_reg <= latch_next;
                    state_reg     <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        alert_reg     <= res_alert_reg;
                        mode_out_reg  <= cfg.enable ? mode_reg : pcsd_pkg::MODE_DIS;
                        thr_out_reg   <= thr_reg;
                        p90_out_reg   <= p90_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* src/percentile_calibrated_streak_detector.sv */
// Top level of the percentile-calibrated streak detector: configuration registers, front and back end.
// Depends on pcsd_pkg, pcsd_front and pcsd_back.
`timescale 1ns / 1ps

// An ordinary traffic window or restart passes from the input queue through the execute
// state, and for an armed window also the judge state, to the output state, which writes
// the result register, waiting there while an earlier result is held and not taken.
// The back end pops the next item only from idle, after that write, so it never takes a
// new item before it is through with the last. The front queue of two entries takes new
// transfers meanwhile. The arming window runs a bitwise rank selection over the n stored
// counts through the single read port of the sample ring, scanning it once per count bit.
// Configuration may be written only while the block is idle.
module percentile_calibrated_streak_detector #(
    parameter int RING_DEPTH = pcsd_pkg::RING_DEPTH_DEF,
    parameter int COUNT_BITS = pcsd_pkg::COUNT_BITS_DEF,
    parameter int TIME_BITS  = pcsd_pkg::TIME_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  opcode,
    input  logic [TIME_BITS-1:0]  now_ms,
    input  logic [COUNT_BITS-1:0] packet_count,
    input  logic                  deauth_seen,
    input  logic                  raw_alert,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  alert,
    output logic [1:0]            mode,
    output logic [31:0]           threshold_q8,
    output logic [COUNT_BITS-1:0] p90_count
);

    localparam int ITEM_W = 3 + TIME_BITS + COUNT_BITS;

    pcsd_pkg::cfg_t    cfg_reg;
    logic              wr_en;
    logic [2:0]        reg_idx;
    logic              q_valid;
    logic [ITEM_W-1:0] q_item;
    logic              q_pop;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable             <= 1'b1;
            cfg_reg.calib_time_ms      <= 32'd45000;
            cfg_reg.gain_q8            <= 16'd512;
            cfg_reg.streak_need        <= 8'd3;
            cfg_reg.deauth_streak_need <= 8'd1;
            cfg_reg.clear_need         <= 8'd2;
            cfg_reg.min_samples        <= 8'd32;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                pcsd_pkg::REG_ENABLE:      cfg_reg.enable             <= pwdata[0];
                pcsd_pkg::REG_CALIB_TIME:  cfg_reg.calib_time_ms      <= pwdata;
                pcsd_pkg::REG_GAIN:        cfg_reg.gain_q8            <= pwdata[15:0];
                pcsd_pkg::REG_STREAK_NEED: cfg_reg.streak_need        <= pwdata[7:0];
                pcsd_pkg::REG_DEAUTH_NEED: cfg_reg.deauth_streak_need <= pwdata[7:0];
                pcsd_pkg::REG_CLEAR_NEED:  cfg_reg.clear_need         <= pwdata[7:0];
                pcsd_pkg::REG_MIN_SAMPLES: cfg_reg.min_samples        <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            pcsd_pkg::REG_ENABLE:      prdata = {31'd0, cfg_reg.enable};
            pcsd_pkg::REG_CALIB_TIME:  prdata = cfg_reg.calib_time_ms;
            pcsd_pkg::REG_GAIN:        prdata = {16'd0, cfg_reg.gain_q8};
            pcsd_pkg::REG_STREAK_NEED: prdata = {24'd0, cfg_reg.streak_need};
            pcsd_pkg::REG_DEAUTH_NEED: prdata = {24'd0, cfg_reg.deauth_streak_need};
            pcsd_pkg::REG_CLEAR_NEED:  prdata = {24'd0, cfg_reg.clear_need};
            pcsd_pkg::REG_MIN_SAMPLES: prdata = {24'd0, cfg_reg.min_samples};
            default:                   prdata = 32'd0;
        endcase
    end

    pcsd_front #(
        .COUNT_BITS (COUNT_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid        (in_valid),
        .ready        (in_ready),
        .opcode       (opcode),
        .now_ms       (now_ms),
        .packet_count (packet_count),
        .deauth_seen  (deauth_seen),
        .raw_alert    (raw_alert),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    pcsd_back #(
        .RING_DEPTH (RING_DEPTH),
        .COUNT_BITS (COUNT_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .alert        (alert),
        .mode         (mode),
        .threshold_q8 (threshold_q8),
        .p90_count    (p90_count)
    );

endmodule
